### rtl/avsq_pkg.sv
package avsq_pkg;

   // Field widths
   localparam int TIME_W   = 64;
   localparam int FRAMES_W = 16;
   localparam int HANDLE_W = 16;
   localparam int PAD_W    = 18;
   localparam int RATE_W   = 19;
   localparam int ACTION_W = 2;
   localparam int NS_W     = 48;   // frames * 1e9 fits below 2^48 for 18-bit counts

   localparam int REQ_DATA_W = 248;
   localparam int RSP_DATA_W = 32;

   localparam int QUEUE_DEPTH_DEFAULT = 32;

   // Timing constants in nanoseconds, plus the reset sample rate
   localparam logic [NS_W-1:0]         NS_PER_SEC  = NS_W'(1000000000);
   localparam logic [TIME_W-1:0]       GAP_LIMIT   = 64'd1000000000;
   localparam logic [TIME_W-1:0]       STALL_LIMIT = 64'd100000000;
   localparam logic signed [TIME_W-1:0] FAR_LIMIT  = 64'sd5000000000;
   localparam logic signed [TIME_W-1:0] SYNC_WINDOW = 64'sd75000000;
   localparam logic [RATE_W-1:0]       RATE_RESET  = 19'd48000;

   typedef enum logic [ACTION_W-1:0] {
      ACT_PLAY      = 2'd0,
      ACT_DROP_LATE = 2'd1,
      ACT_HOLD      = 2'd2,
      ACT_DROP_OVF  = 2'd3
   } action_type;

   // How stall time moves for the current packet
   typedef enum logic [1:0] {
      STALL_KEEP,
      STALL_ADD,
      STALL_CLEAR
   } stall_mode_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_START_FRM,
      F_WAIT_FRM,
      F_START_PAD,
      F_WAIT_PAD,
      F_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_OVF_RD,
      B_OVF,
      B_ENQ,
      B_WALK_RD,
      B_WALK_ADJ,
      B_WALK_DIFF,
      B_WALK_EVAL
   } back_state_type;

   // Classified packet handed from front to back
   typedef struct packed {
      logic [TIME_W-1:0]   packet_time;
      logic [FRAMES_W-1:0] packet_frames;
      logic [HANDLE_W-1:0] payload_handle;
      logic [NS_W-1:0]     pad_ns;
      logic [TIME_W-1:0]   video_time;
      logic                gap_clear;
      logic                sync_off;
   } job_type;

   typedef struct packed {
      logic [TIME_W-1:0]   entry_time;
      logic [FRAMES_W-1:0] entry_frames;
      logic [HANDLE_W-1:0] entry_handle;
   } entry_type;

endpackage

### rtl/avsq_div.sv
module avsq_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [avsq_pkg::NS_W-1:0]     numer,
   input  logic [avsq_pkg::RATE_W-1:0]   denom,
   output logic                          done,
   output logic [avsq_pkg::NS_W-1:0]     quot
);
   import avsq_pkg::*;

   localparam int CNT_W = $clog2(NS_W + 1);

   logic [NS_W-1:0]   num_ff, num_in;
   logic [RATE_W:0]   rem_ff, rem_in;
   logic [RATE_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [RATE_W+1:0] rem_shift;
   logic              fits;

   // One restoring step per cycle, quotient shifts into the numerator register
   always_comb begin
      num_in    = num_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      rem_shift = {rem_ff, num_ff[NS_W-1]};
      fits      = rem_shift >= {2'b00, den_ff};
      if (start) begin
         num_in  = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_W'(NS_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? (RATE_W+1)'(rem_shift - {2'b00, den_ff}) : rem_shift[RATE_W:0];
         num_in  = {num_ff[NS_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = num_ff;

endmodule

### rtl/avsq_front.sv
module avsq_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [avsq_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [avsq_pkg::RATE_W-1:0]       rate,
   output logic                              job_push,
   output avsq_pkg::job_type                 job_data,
   input  logic                              job_full
);
   import avsq_pkg::*;

   front_state_type     state_ff, state_in;
   logic [TIME_W-1:0]   last_ff, last_in;
   logic [TIME_W-1:0]   first_vid_ff, first_vid_in;
   logic [TIME_W-1:0]   stall_ff, stall_in;
   stall_mode_type      mode_ff, mode_in;
   job_type             job_ff, job_in;
   logic [NS_W-1:0]     num_frm_ff, num_frm_in;
   logic [NS_W-1:0]     num_pad_ff, num_pad_in;

   logic [TIME_W-1:0]   in_time, in_now, in_video;
   logic [FRAMES_W-1:0] in_frame_cnt;
   logic [HANDLE_W-1:0] in_handle;
   logic [PAD_W-1:0]    in_pad;
   logic                div_start, div_done;
   logic [NS_W-1:0]     div_numer, div_quot;
   logic [TIME_W:0]     stall_sum;
   logic                accept;

   assign in_time      = req_tdata[63:0];
   assign in_frame_cnt = req_tdata[79:64];
   assign in_handle    = req_tdata[95:80];
   assign in_pad       = req_tdata[113:96];
   assign in_now       = req_tdata[177:114];
   assign in_video     = req_tdata[241:178];

   assign req_tready = (state_ff == F_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign stall_sum  = {1'b0, stall_ff} + {{(TIME_W-NS_W+1){1'b0}}, div_quot};

   avsq_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_numer),
      .denom (rate),
      .done  (div_done),
      .quot  (div_quot)
   );

   // Classify the beat, then run both frame-to-ns conversions on the shared divider
   always_comb begin
      state_in     = state_ff;
      last_in      = last_ff;
      first_vid_in = first_vid_ff;
      stall_in     = stall_ff;
      mode_in      = mode_ff;
      job_in       = job_ff;
      num_frm_in   = num_frm_ff;
      num_pad_in   = num_pad_ff;
      div_start    = 1'b0;
      div_numer    = num_frm_ff;
      job_push     = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (accept) begin
               job_in.packet_time    = in_time;
               job_in.packet_frames  = in_frame_cnt;
               job_in.payload_handle = in_handle;
               job_in.video_time     = in_video;
               job_in.gap_clear      = (in_now - last_ff) > GAP_LIMIT;
               last_in    = in_now;
               num_frm_in = NS_W'(in_frame_cnt) * NS_PER_SEC;
               num_pad_in = NS_W'(in_pad) * NS_PER_SEC;
               if (first_vid_ff == '0) begin
                  first_vid_in = in_video;
                  mode_in      = STALL_KEEP;
               end else if (first_vid_ff == in_video) begin
                  mode_in = STALL_ADD;
               end else begin
                  mode_in = STALL_CLEAR;
               end
               state_in = F_START_FRM;
            end
         end
         F_START_FRM: begin
            div_start = 1'b1;
            div_numer = num_frm_ff;
            state_in  = F_WAIT_FRM;
         end
         F_WAIT_FRM: begin
            if (div_done) begin
               unique case (mode_ff)
                  STALL_ADD:   stall_in = stall_sum[TIME_W] ? '1 : stall_sum[TIME_W-1:0];
                  STALL_CLEAR: stall_in = '0;
                  default:     stall_in = stall_ff;
               endcase
               state_in = F_START_PAD;
            end
         end
         F_START_PAD: begin
            div_start = 1'b1;
            div_numer = num_pad_ff;
            state_in  = F_WAIT_PAD;
         end
         F_WAIT_PAD: begin
            if (div_done) begin
               job_in.pad_ns   = div_quot;
               job_in.sync_off = (job_ff.video_time == '0) || (stall_ff > STALL_LIMIT);
               state_in        = F_PUSH;
            end
         end
         F_PUSH: begin
            if (!job_full) begin
               job_push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= F_IDLE;
         last_ff      <= '0;
         first_vid_ff <= '0;
         stall_ff     <= '0;
         mode_ff      <= STALL_KEEP;
      end else begin
         state_ff     <= state_in;
         last_ff      <= last_in;
         first_vid_ff <= first_vid_in;
         stall_ff     <= stall_in;
         mode_ff      <= mode_in;
      end
      job_ff     <= job_in;
      num_frm_ff <= num_frm_in;
      num_pad_ff <= num_pad_in;
   end

   assign job_data = job_ff;

endmodule

### rtl/avsq_job_fifo.sv
module avsq_job_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  avsq_pkg::job_type push_data,
   output logic              full,
   input  logic              pop,
   output avsq_pkg::job_type pop_data,
   output logic              empty
);
   import avsq_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] fill_ff;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   // Two-slot ring between front and back
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### rtl/avsq_back.sv
module avsq_back #(
   parameter int QUEUE_DEPTH = avsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              job_empty,
   input  avsq_pkg::job_type                 job_data,
   output logic                              job_pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [avsq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [avsq_pkg::ACTION_W-1:0]     rsp_tuser,
   output logic                              rsp_tlast
);
   import avsq_pkg::*;

   localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   entry_type mem [QUEUE_DEPTH];
   entry_type rd_ff;

   back_state_type             state_ff, state_in;
   job_type                    job_ff, job_in;
   logic [HEAD_W-1:0]          head_ff, head_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [TIME_W-1:0]          adj_ff, adj_in;
   logic signed [TIME_W-1:0]   diff_ff, diff_in;
   logic                       out_valid_ff, out_valid_in;
   action_type                 out_action_ff, out_action_in;
   logic [HANDLE_W-1:0]        out_handle_ff, out_handle_in;
   logic [FRAMES_W-1:0]        out_frames_ff, out_frames_in;
   logic                       out_last_ff, out_last_in;

   logic                       out_free;
   logic                       mem_we;
   logic [COUNT_W:0]           tail_sum;
   logic [HEAD_W-1:0]          tail;
   logic [HEAD_W-1:0]          head_next;
   logic                       bad, early, late;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign tail_sum  = (COUNT_W+1)'(head_ff) + (COUNT_W+1)'(count_ff);
   assign tail      = (tail_sum >= (COUNT_W+1)'(QUEUE_DEPTH))
                      ? HEAD_W'(tail_sum - (COUNT_W+1)'(QUEUE_DEPTH))
                      : HEAD_W'(tail_sum);
   assign head_next = (head_ff == HEAD_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign bad   = job_ff.sync_off || (diff_ff > FAR_LIMIT) || (diff_ff < -FAR_LIMIT);
   assign early = !bad && (diff_ff > SYNC_WINDOW);
   assign late  = !bad && (diff_ff < -SYNC_WINDOW);

   // Queue sequencer: clear on a gap, overflow drop, enqueue, then walk the front
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      adj_in        = adj_ff;
      diff_in       = diff_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_action_in = out_action_ff;
      out_handle_in = out_handle_ff;
      out_frames_in = out_frames_ff;
      out_last_in   = out_last_ff;
      job_pop       = 1'b0;
      mem_we        = 1'b0;
      unique case (state_ff)
         B_IDLE: begin
            if (!job_empty) begin
               job_pop = 1'b1;
               job_in  = job_data;
               if (job_data.gap_clear) begin
                  head_in  = '0;
                  count_in = '0;
               end
               state_in = B_OVF_RD;
            end
         end
         B_OVF_RD: state_in = B_OVF;
         B_OVF: begin
            if (count_ff != COUNT_W'(QUEUE_DEPTH)) begin
               state_in = B_ENQ;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_action_in = ACT_DROP_OVF;
               out_handle_in = rd_ff.entry_handle;
               out_frames_in = rd_ff.entry_frames;
               out_last_in   = 1'b0;
               head_in       = head_next;
               count_in      = count_ff - 1'b1;
               state_in      = B_ENQ;
            end
         end
         B_ENQ: begin
            mem_we   = 1'b1;
            count_in = count_ff + 1'b1;
            state_in = B_WALK_RD;
         end
         B_WALK_RD:   state_in = B_WALK_ADJ;
         B_WALK_ADJ: begin
            adj_in   = rd_ff.entry_time - TIME_W'(job_ff.pad_ns);
            state_in = B_WALK_DIFF;
         end
         B_WALK_DIFF: begin
            diff_in  = signed'(adj_ff - job_ff.video_time);
            state_in = B_WALK_EVAL;
         end
         B_WALK_EVAL: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               if (early) begin
                  out_action_in = ACT_HOLD;
                  out_handle_in = '0;
                  out_frames_in = '0;
                  out_last_in   = 1'b1;
                  state_in      = B_IDLE;
               end else begin
                  out_handle_in = rd_ff.entry_handle;
                  out_frames_in = rd_ff.entry_frames;
                  head_in       = head_next;
                  count_in      = count_ff - 1'b1;
                  if (late && (count_ff > COUNT_W'(1))) begin
                     out_action_in = ACT_DROP_LATE;
                     out_last_in   = 1'b0;
                     state_in      = B_WALK_RD;
                  end else begin
                     out_action_in = ACT_PLAY;
                     out_last_in   = 1'b1;
                     state_in      = B_IDLE;
                  end
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
      job_ff        <= job_in;
      adj_ff        <= adj_in;
      diff_ff       <= diff_in;
      out_action_ff <= out_action_in;
      out_handle_ff <= out_handle_in;
      out_frames_ff <= out_frames_in;
      out_last_ff   <= out_last_in;
   end

   // Entry store: write at the tail, registered read at the head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail] <= '{entry_time:   job_ff.packet_time,
                        entry_frames: job_ff.packet_frames,
                        entry_handle: job_ff.payload_handle};
      end
      rd_ff <= mem[head_ff];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_frames_ff, out_handle_ff};
   assign rsp_tuser  = out_action_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

### rtl/av_sync_audio_delay_queue_top.sv
// Audio/video sync delay queue. Each req beat is one audio packet descriptor; the block
// queues it (up to QUEUE_DEPTH entries) and answers with one or more rsp beats, the last
// marked by tlast: drop-on-overflow of the oldest entry, any late drops, then a play or a
// hold. The front converts frame counts to nanoseconds on one shared 48-step bit-serial
// divider, twice per packet, and takes no new packet until the last one is queued for
// the back; the back walks the queued entries and stalls while rsp is stalled, and
// the two overlap through a two-slot queue. A sample_rate write of 0 acts as 1. Write
// csr only while idle.
module av_sync_audio_delay_queue_top #(
   parameter int QUEUE_DEPTH = avsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // csr: sample_rate
   input  logic                              csr_we,
   input  logic [avsq_pkg::RATE_W-1:0]       csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // packet_time, packet_frames, payload_handle, pad_frames, now_time, video_time
   input  logic [avsq_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_handle, out_frames
   output logic [avsq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // action
   output logic [avsq_pkg::ACTION_W-1:0]     rsp_tuser,
   output logic                              rsp_tlast
);
   import avsq_pkg::*;

   logic [RATE_W-1:0] rate_ff;
   logic [RATE_W-1:0] rate_eff;
   logic              job_push, job_pop, job_full, job_empty;
   job_type           job_wr, job_rd;

   // Hold the sample rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= RATE_RESET;
      end else if (csr_we) begin
         rate_ff <= csr_wdata;
      end
   end

   assign rate_eff = (rate_ff == '0) ? RATE_W'(1) : rate_ff;

   avsq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rate       (rate_eff),
      .job_push   (job_push),
      .job_data   (job_wr),
      .job_full   (job_full)
   );

   avsq_job_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_rd),
      .empty     (job_empty)
   );

   avsq_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_empty  (job_empty),
      .job_data   (job_rd),
      .job_pop    (job_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
